// ----- rtl/rvmd_pkg.sv -----
// Package: shared types and constants of the RSSI variance motion detector.
package rvmd_pkg;
    localparam int RSSI_W = 13;
    localparam int SD_W = 11;
    localparam int MIN_FILL = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_SQRT,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        REG_TRIP_THR,
        REG_TRIP_NEED,
        REG_TWO_THR,
        REG_SIM_WIN
    } reg_idx_t;

    typedef enum logic [1:0] {
        LINK_CLEAR,
        LINK_ALERT,
        LINK_MOTION
    } link_state_t;

    typedef struct packed {
        logic start;
        logic accum;
        logic prep;
        logic div_step;
        logic sqrt_step;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic accum_done;
        logic div_done;
        logic sqrt_done;
    } status_t;
endpackage

// ----- rtl/rvmd_if.sv -----
// Interface: valid/ready channel for input samples and results.
interface rvmd_in_if;
    logic        valid;
    logic        ready;
    logic        link;
    logic signed [12:0] rssi;
    logic [31:0] time_ms;
    modport source (output valid, link, rssi, time_ms, input ready);
    modport sink (input valid, link, rssi, time_ms, output ready);
endinterface

interface rvmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  link_status;
    logic [10:0] std_dev;
    logic        event_active;
    logic [1:0]  person_count;
    logic        first_link;
    logic        direction_new;
    logic [31:0] trip_gap_ms;
    logic        direction_seen;
    logic        event_ended;
    logic [31:0] event_duration_ms;
    modport source (output valid, link_status, std_dev, event_active, person_count,
        first_link, direction_new, trip_gap_ms, direction_seen, event_ended,
        event_duration_ms, input ready);
    modport sink (input valid, link_status, std_dev, event_active, person_count,
        first_link, direction_new, trip_gap_ms, direction_seen, event_ended,
        event_duration_ms, output ready);
endinterface

// ----- rtl/rvmd_ram.sv -----
// Generic single-port-write, registered-read RAM.
module rvmd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rvmd_ctrl.sv -----
// Controller: sequences accumulate, divide, square root and update per sample.
module rvmd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output rvmd_pkg::cmd_t     cmd,
    input  rvmd_pkg::status_t  sts
);
    rvmd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rvmd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            rvmd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    state_next = rvmd_pkg::ST_ACCUM;
                end
            end
            rvmd_pkg::ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (sts.accum_done)
                begin
                    state_next = rvmd_pkg::ST_PREP;
                end
            end
            rvmd_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = rvmd_pkg::ST_DIV;
            end
            rvmd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = rvmd_pkg::ST_SQRT;
                end
            end
            rvmd_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    state_next = rvmd_pkg::ST_UPDATE;
                end
            end
            rvmd_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = rvmd_pkg::ST_OUT;
            end
            rvmd_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = rvmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rvmd_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/rvmd_datapath.sv -----
// Datapath: sample rings, window sums, divider, square root and event tracking.
module rvmd_datapath #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rvmd_pkg::cmd_t     cmd,
    output rvmd_pkg::status_t  sts,
    input  logic               in_link,
    input  logic signed [12:0] in_rssi,
    input  logic [31:0]        in_time_ms,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic [1:0]         link_status,
    output logic [10:0]        std_dev,
    output logic               event_active,
    output logic [1:0]         person_count,
    output logic               first_link,
    output logic               direction_new,
    output logic [31:0]        trip_gap_ms,
    output logic               direction_seen,
    output logic               event_ended,
    output logic [31:0]        event_duration_ms
);
    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int AW = PW + 1;
    localparam int SUM_W = 13 + FW + 1;
    localparam int SQ_W = 26 + FW;
    localparam int NUM_W = SQ_W + FW + 1;
    localparam int DEN_W = 2 * FW;
    // root pairs must line up with bit 0, so the radicand width is even
    localparam int VAR_W = NUM_W + (NUM_W % 2);
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int RT_W = (VAR_W + 1) / 2;
    localparam int RT_CNT_W = $clog2(RT_W + 1);
    localparam int RING_DEPTH = 2 * (2 ** PW);

    logic [10:0] thr_reg;
    logic [7:0]  need_reg;
    logic [11:0] two_thr_reg;
    logic [15:0] win_reg;

    logic [PW-1:0] wpos_reg [2];
    logic [FW-1:0] fill_reg [2];
    logic [7:0]    over_reg [2];
    logic [1:0]    trip_reg;
    logic [10:0]   peak_reg [2];
    logic [31:0]   tstart_reg [2];
    logic          ev_active_reg, ev_dir_reg, ev_first_reg;
    logic [31:0]   ev_begin_reg;
    logic [11:0]   ev_peak_reg;
    logic [1:0]    ev_persons_reg;

    logic              link_reg;
    logic [31:0]       time_reg;
    logic [FW-1:0]     n_reg;
    logic [FW:0]       rd_cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]   sumsq_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [VAR_W-1:0]  rv_reg;
    logic [RT_W-1:0]   root_reg;
    logic [RT_W+1:0]   rrem_reg;
    logic [RT_CNT_W-1:0] rt_cnt_reg;
    logic signed [25:0] mul_reg;
    logic              mul_v_reg;

    logic [1:0]  status_reg;
    logic [10:0] sd_reg;
    logic        dir_new_reg, ended_reg;
    logic [31:0] dur_reg;

    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [12:0]    ram_rdata;

    rvmd_ram #(.WIDTH(13), .DEPTH(RING_DEPTH)) u_ring (
        .clk   (clk),
        .we    (cmd.start),
        .waddr (ram_waddr),
        .wdata (in_rssi),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = {in_link, wpos_reg[in_link]};
    assign ram_raddr = {link_reg, rd_cnt_reg[PW-1:0]};

    assign sts.accum_done = (rd_cnt_reg == FW'(n_reg) + (FW+1)'(1)) && !mul_v_reg;
    assign sts.div_done = (div_cnt_reg == '0);
    assign sts.sqrt_done = (rt_cnt_reg == '0);

    // Restoring division step.
    logic [NUM_W:0] div_trial;
    logic [NUM_W-1:0] div_shift;
    always_comb
    begin
        div_shift = {rem_reg[NUM_W-2:0], quo_reg[NUM_W-1]};
        div_trial = {1'b0, div_shift} - (NUM_W+1)'(den_reg);
    end

    // Non-restoring-free digit-by-digit square root, two bits per step.
    logic [RT_W+1:0] rt_part;
    logic [RT_W+1:0] rt_trial;
    logic [1:0]      rt_pair;
    always_comb
    begin
        rt_pair = rv_reg[VAR_W-1 -: 2];
        rt_part = {rrem_reg[RT_W-1:0], rt_pair};
        rt_trial = rt_part - {root_reg, 2'b01};
    end

    // Numerator n*sumsq - sum^2, clamped at zero.
    logic signed [NUM_W:0] num_full;
    logic signed [2*SUM_W-1:0] sum_sq;
    always_comb
    begin
        sum_sq = sum_reg * sum_reg;
        num_full = $signed({1'b0, (NUM_W)'(sumsq_reg) * (NUM_W)'(n_reg)})
            - (NUM_W+1)'(sum_sq);
    end

    logic [10:0] sd_val;
    assign sd_val = (root_reg > RT_W'(2047)) ? 11'd2047 : root_reg[10:0];

    // Event update combinational view.
    logic        l;
    logic [7:0]  over_inc;
    logic [7:0]  need_eff;
    logic        over_thr;
    logic [1:0]  trip_n;
    logic [10:0] peak_n [2];
    logic [31:0] ts_n [2];
    logic        act_n, dir_n, first_n, fresh, ended_n;
    logic [11:0] evpk_n;
    logic [1:0]  pers_n;
    logic [31:0] begin_n;
    logic [12:0] combined;
    logic        simul;
    logic [1:0]  stat_n;

    always_comb
    begin
        l = link_reg;
        over_inc = (over_reg[l] == 8'hFF) ? over_reg[l] : over_reg[l] + 8'd1;
        need_eff = (need_reg == 8'd0) ? 8'd1 : need_reg;
        over_thr = (sd_val >= thr_reg);
        trip_n = trip_reg;
        peak_n = peak_reg;
        ts_n = tstart_reg;
        act_n = ev_active_reg;
        dir_n = ev_dir_reg;
        first_n = ev_first_reg;
        evpk_n = ev_peak_reg;
        pers_n = ev_persons_reg;
        begin_n = ev_begin_reg;
        fresh = 1'b0;
        ended_n = 1'b0;
        stat_n = rvmd_pkg::LINK_CLEAR;
        combined = '0;
        simul = 1'b0;
        if (over_thr)
        begin
            if (over_inc >= need_eff)
            begin
                if (!trip_reg[l])
                begin
                    trip_n[l] = 1'b1;
                    ts_n[l] = time_reg;
                    peak_n[l] = sd_val;
                    if (!ev_active_reg)
                    begin
                        act_n = 1'b1;
                        begin_n = time_reg;
                        evpk_n = '0;
                        pers_n = '0;
                        first_n = l;
                        dir_n = 1'b0;
                    end
                end
                if (sd_val > peak_n[l])
                begin
                    peak_n[l] = sd_val;
                end
                stat_n = rvmd_pkg::LINK_MOTION;
                combined = (trip_n[0] ? 13'(peak_n[0]) : 13'd0)
                    + (trip_n[1] ? 13'(peak_n[1]) : 13'd0);
                if (trip_n[0] && trip_n[1])
                begin
                    simul = 32'(ts_n[0] > ts_n[1] ? ts_n[0] - ts_n[1] : ts_n[1] - ts_n[0])
                        < 32'(win_reg);
                    if (!dir_n)
                    begin
                        dir_n = 1'b1;
                        fresh = 1'b1;
                    end
                end
                if (combined > 13'(evpk_n))
                begin
                    evpk_n = combined[11:0];
                end
                pers_n = (simul && evpk_n >= two_thr_reg) ? 2'd2 : 2'd1;
            end
            else
            begin
                stat_n = rvmd_pkg::LINK_ALERT;
            end
        end
        else
        begin
            if (trip_reg[l])
            begin
                trip_n[l] = 1'b0;
                peak_n[l] = '0;
            end
            if (trip_n == 2'b00 && ev_active_reg)
            begin
                ended_n = 1'b1;
                act_n = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 11'd24;
            need_reg <= 8'd2;
            two_thr_reg <= 12'd120;
            win_reg <= 16'd2000;
            for (int i = 0; i < 2; i++)
            begin
                wpos_reg[i] <= '0;
                fill_reg[i] <= '0;
                over_reg[i] <= '0;
                peak_reg[i] <= '0;
                tstart_reg[i] <= '0;
            end
            trip_reg <= '0;
            ev_active_reg <= 1'b0;
            ev_dir_reg <= 1'b0;
            ev_first_reg <= 1'b0;
            ev_begin_reg <= '0;
            ev_peak_reg <= '0;
            ev_persons_reg <= '0;
            status_reg <= '0;
            sd_reg <= '0;
            dir_new_reg <= 1'b0;
            ended_reg <= 1'b0;
            dur_reg <= '0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rvmd_pkg::REG_TRIP_THR:  thr_reg <= cfg_data[10:0];
                    rvmd_pkg::REG_TRIP_NEED: need_reg <= cfg_data[7:0];
                    rvmd_pkg::REG_TWO_THR:   two_thr_reg <= cfg_data[11:0];
                    rvmd_pkg::REG_SIM_WIN:   win_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.start)
            begin
                wpos_reg[in_link] <= (32'(wpos_reg[in_link]) == WINDOW_DEPTH - 1)
                    ? '0 : wpos_reg[in_link] + PW'(1);
                if (32'(fill_reg[in_link]) < WINDOW_DEPTH)
                begin
                    fill_reg[in_link] <= fill_reg[in_link] + FW'(1);
                end
            end
            mul_v_reg <= cmd.accum && (rd_cnt_reg != '0)
                && (rd_cnt_reg <= (FW+1)'(n_reg));
            if (cmd.update)
            begin
                over_reg[l] <= over_thr ? over_inc : 8'd0;
                trip_reg <= trip_n;
                peak_reg <= peak_n;
                tstart_reg <= ts_n;
                ev_active_reg <= act_n;
                ev_dir_reg <= dir_n;
                ev_first_reg <= first_n;
                ev_begin_reg <= begin_n;
                ev_peak_reg <= evpk_n;
                ev_persons_reg <= pers_n;
                status_reg <= stat_n;
                sd_reg <= sd_val;
                dir_new_reg <= fresh;
                ended_reg <= ended_n;
                dur_reg <= ended_n ? time_reg - ev_begin_reg : 32'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            link_reg <= in_link;
            time_reg <= in_time_ms;
            n_reg <= (32'(fill_reg[in_link]) < WINDOW_DEPTH)
                ? fill_reg[in_link] + FW'(1) : fill_reg[in_link];
            rd_cnt_reg <= '0;
            sum_reg <= '0;
            sumsq_reg <= '0;
        end
        if (cmd.accum)
        begin
            if (rd_cnt_reg <= (FW+1)'(n_reg))
            begin
                rd_cnt_reg <= rd_cnt_reg + (FW+1)'(1);
            end
            if (rd_cnt_reg != '0 && rd_cnt_reg <= (FW+1)'(n_reg))
            begin
                mul_reg <= $signed(ram_rdata) * $signed(ram_rdata);
                sum_reg <= sum_reg + SUM_W'($signed(ram_rdata));
            end
            if (mul_v_reg)
            begin
                sumsq_reg <= sumsq_reg + SQ_W'($unsigned(mul_reg));
            end
        end
        if (cmd.prep)
        begin
            quo_reg <= num_full[NUM_W] ? '0 : num_full[NUM_W-1:0];
            rem_reg <= '0;
            den_reg <= DEN_W'(n_reg) * DEN_W'(n_reg);
            div_cnt_reg <= DIV_CNT_W'(NUM_W);
        end
        if (cmd.div_step)
        begin
            if (div_cnt_reg != '0)
            begin
                if (!div_trial[NUM_W])
                begin
                    rem_reg <= div_trial[NUM_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_shift;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end
            else
            begin
                rv_reg <= (32'(n_reg) < rvmd_pkg::MIN_FILL) ? '0 : VAR_W'(quo_reg);
                root_reg <= '0;
                rrem_reg <= '0;
                rt_cnt_reg <= RT_CNT_W'(RT_W);
            end
        end
        if (cmd.sqrt_step && rt_cnt_reg != '0)
        begin
            if (!rt_trial[RT_W+1])
            begin
                rrem_reg <= rt_trial;
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rt_part;
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
            rv_reg <= {rv_reg[VAR_W-3:0], 2'b00};
            rt_cnt_reg <= rt_cnt_reg - RT_CNT_W'(1);
        end
    end

    assign link_status = status_reg;
    assign std_dev = sd_reg;
    assign event_active = ev_active_reg;
    assign person_count = ev_persons_reg;
    assign first_link = ev_first_reg;
    assign direction_new = dir_new_reg;
    assign trip_gap_ms = tstart_reg[0] > tstart_reg[1] ? tstart_reg[0] - tstart_reg[1]
        : tstart_reg[1] - tstart_reg[0];
    assign direction_seen = ev_dir_reg;
    assign event_ended = ended_reg;
    assign event_duration_ms = dur_reg;
endmodule

// ----- rtl/rssi_variance_motion_detector.sv -----
// Top level: RSSI variance motion detector for two radio links.
//
// Channel in carries one sample (link, rssi, time_ms) per transfer; channel
// out returns exactly one result per sample. The block holds one sample at a
// time: in.ready is high only in the idle state.
// Per sample: an accept state, accumulation over the n stored samples of
// the link's ring (n = fill, up to WINDOW_DEPTH), a setup state, a
// bit-serial restoring divider plus a finish step, a digit-by-digit square
// root, then an update state and an output state.
// The result waits in the output register until out.ready; the next sample
// is taken the cycle after that transfer.
// Reset is asynchronous, active low, and restores default thresholds, empty
// windows and no event. Configuration writes go to cfg_we/cfg_index/cfg_data
// and should be made only while idle.
module rssi_variance_motion_detector #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rvmd_in_if.sink     in,
    rvmd_out_if.source  out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    rvmd_pkg::cmd_t    cmd;
    rvmd_pkg::status_t sts;

    rvmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rvmd_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_link           (in.link),
        .in_rssi           (in.rssi),
        .in_time_ms        (in.time_ms),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .link_status       (out.link_status),
        .std_dev           (out.std_dev),
        .event_active      (out.event_active),
        .person_count      (out.person_count),
        .first_link        (out.first_link),
        .direction_new     (out.direction_new),
        .trip_gap_ms       (out.trip_gap_ms),
        .direction_seen    (out.direction_seen),
        .event_ended       (out.event_ended),
        .event_duration_ms (out.event_duration_ms)
    );
endmodule

// ----- rtl/rvmd_checker.sv -----
// Checker: port-level assertions for the motion detector, bound to the top.
module rvmd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] link_status,
    input logic       event_active,
    input logic       event_ended,
    input logic       direction_new,
    input logic       direction_seen
);
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second item taken");
    a_ended: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_ended |-> !event_active && link_status == rvmd_pkg::LINK_CLEAR)
        else $error("event ended while active");
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && direction_new |-> direction_seen
            && link_status == rvmd_pkg::LINK_MOTION)
        else $error("direction pulse without flag");
endmodule

bind rssi_variance_motion_detector rvmd_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in.valid),
    .in_ready       (in.ready),
    .out_valid      (out.valid),
    .out_ready      (out.ready),
    .link_status    (out.link_status),
    .event_active   (out.event_active),
    .event_ended    (out.event_ended),
    .direction_new  (out.direction_new),
    .direction_seen (out.direction_seen)
);
